/* hw/rtl/srtpq_pkg.sv */
`timescale 1ns / 1ps

package srtpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int PRIO_W  = 4;
  localparam int PLATE_W = 32;
  localparam int TIME_W  = 17;
  localparam int COUNT_W = 5;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_PUT,
    ST_POP_MV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [PLATE_W-1:0] plate_id;
    logic [PRIO_W-1:0]  new_priority;
    logic [TIME_W-1:0]  entry_time;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               head_valid;
    logic [PLATE_W-1:0] head_plate;
    logic [PRIO_W-1:0]  head_priority;
    logic [TIME_W-1:0]  head_time;
    logic [COUNT_W-1:0] entry_count;
  } out_rsp_t;

  // one stored queue slot
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [PLATE_W-1:0] plate;
    logic [TIME_W-1:0]  tstamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/srtpq_in_if.sv */
`timescale 1ns / 1ps

interface srtpq_in_if;
  logic               valid;
  logic               ready;
  srtpq_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/srtpq_out_if.sv */
`timescale 1ns / 1ps

interface srtpq_out_if;
  logic                valid;
  logic                ready;
  srtpq_pkg::out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                             | Notes
// request  | in  | mode, plate_id, new_priority, entry_time            | taken only in IDLE
// result   | out | status, head_valid, head_plate, head_priority,     | one per request
//          |     | head_time, entry_count                              |
//
// Flow: peek and error requests go from IDLE through DONE to a loaded result. An
//   insert walks the slot RAM from the tail toward the head, one slot per cycle,
//   then writes the new entry in PUT; a pop moves slots toward the head in POP_MV.
//   The single read port of the slot RAM sets the pace, one slot moved per cycle.
// Reset: synchronous, clears count, the result valid flag and the control
//   state. Slot RAM and head content are not cleared; they are only read
//   while count is nonzero.
// Stalls: the result register holds a finished result while the next request
//   is taken; a request waits in DONE only while that register is still full.

module sorted_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  srtpq_in_if.sink    request,
  srtpq_out_if.source result
);

  localparam int IDX_W = srtpq_pkg::IDX_W;
  localparam int CNT_W = srtpq_pkg::CNT_W;

  srtpq_pkg::state_t  state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   idx, idx_next;          // walk index, then insert position
  srtpq_pkg::in_req_t req, req_next;
  srtpq_pkg::entry_t  head, head_next;
  srtpq_pkg::status_t status, status_next;

  logic                rsp_valid, rsp_valid_next;
  srtpq_pkg::out_rsp_t rsp, rsp_next;
  logic                out_load;

  // slot RAM port signals
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_wr_addr;
  srtpq_pkg::entry_t            ram_wr_data;
  logic [IDX_W-1:0]             ram_rd_addr;
  logic [srtpq_pkg::ENTRY_W-1:0] ram_rd_raw;
  srtpq_pkg::entry_t            rd_entry;
  srtpq_pkg::entry_t            new_entry;
  logic                         moves;
  logic [CNT_W-1:0]             idx_ext;

  srtpq_ram #(
    .WIDTH(srtpq_pkg::ENTRY_W),
    .DEPTH(srtpq_pkg::DEPTH)
  ) u_slots (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_raw)
  );

  assign rd_entry         = srtpq_pkg::entry_t'(ram_rd_raw);
  assign new_entry.prio   = req.new_priority;
  assign new_entry.plate  = req.plate_id;
  assign new_entry.tstamp = req.entry_time;
  assign idx_ext          = CNT_W'(idx);

  // The shared compare: slot 0 moves only if strictly greater, others if >=.
  assign moves = (idx == '0) ? (rd_entry.prio > req.new_priority)
                             : (rd_entry.prio >= req.new_priority);

  assign request.ready = (state == srtpq_pkg::ST_IDLE);
  assign result.valid  = rsp_valid;
  assign result.data   = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srtpq_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    req    <= req_next;
    head   <= head_next;
    status <= status_next;
    rsp    <= rsp_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    req_next    = req;
    head_next   = head;
    status_next = status;
    ram_we      = 1'b0;
    ram_wr_addr = idx;
    ram_wr_data = rd_entry;
    ram_rd_addr = '0;
    out_load    = 1'b0;
    rsp_next    = rsp;

    case (state)
      srtpq_pkg::ST_IDLE: begin
        if (request.valid) begin
          req_next    = request.data;
          status_next = srtpq_pkg::STATUS_OK;
          state_next  = srtpq_pkg::ST_DONE;
          case (request.data.mode)
            srtpq_pkg::MODE_INSERT: begin
              if (count == CNT_W'(srtpq_pkg::DEPTH)) begin
                status_next = srtpq_pkg::STATUS_FULL;
              end else if (count == '0) begin
                idx_next   = '0;
                state_next = srtpq_pkg::ST_PUT;
              end else begin
                // start the walk at the tail
                ram_rd_addr = IDX_W'(count - 1'b1);
                idx_next    = IDX_W'(count - 1'b1);
                state_next  = srtpq_pkg::ST_INS_CMP;
              end
            end
            srtpq_pkg::MODE_POP: begin
              if (count == '0) begin
                status_next = srtpq_pkg::STATUS_EMPTY;
              end else if (count == CNT_W'(1)) begin
                count_next = count - 1'b1;
              end else begin
                ram_rd_addr = IDX_W'(1);
                idx_next    = IDX_W'(1);
                state_next  = srtpq_pkg::ST_POP_MV;
              end
            end
            default: begin
              // peek, and the unused code as a peek
            end
          endcase
        end
      end

      srtpq_pkg::ST_INS_CMP: begin
        if (moves) begin
          ram_we      = 1'b1;
          ram_wr_addr = idx + 1'b1;
          ram_wr_data = rd_entry;
          if (idx == '0) begin
            state_next = srtpq_pkg::ST_PUT;
          end else begin
            ram_rd_addr = idx - 1'b1;
            idx_next    = idx - 1'b1;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = srtpq_pkg::ST_PUT;
        end
      end

      srtpq_pkg::ST_PUT: begin
        ram_we      = 1'b1;
        ram_wr_addr = idx;
        ram_wr_data = new_entry;
        if (idx == '0) begin
          head_next = new_entry;
        end
        count_next = count + 1'b1;
        state_next = srtpq_pkg::ST_DONE;
      end

      srtpq_pkg::ST_POP_MV: begin
        ram_we      = 1'b1;
        ram_wr_addr = idx - 1'b1;
        ram_wr_data = rd_entry;
        if (idx == IDX_W'(1)) begin
          head_next = rd_entry;
        end
        if ((idx_ext + 1'b1) < count) begin
          ram_rd_addr = idx + 1'b1;
          idx_next    = idx + 1'b1;
        end else begin
          count_next = count - 1'b1;
          state_next = srtpq_pkg::ST_DONE;
        end
      end

      srtpq_pkg::ST_DONE: begin
        if (!rsp_valid || result.ready) begin
          out_load               = 1'b1;
          rsp_next.status        = status;
          rsp_next.head_valid    = (count != '0);
          rsp_next.head_plate    = (count != '0) ? head.plate : '0;
          rsp_next.head_priority = (count != '0) ? head.prio : '0;
          rsp_next.head_time     = (count != '0) ? head.tstamp : '0;
          rsp_next.entry_count   = srtpq_pkg::COUNT_W'(count);
          state_next             = srtpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = srtpq_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      rsp_valid_next = 1'b1;
    end else if (result.ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  // count never runs past the slot RAM
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(srtpq_pkg::DEPTH))
    else $error("count above depth");

  // a write never lands beyond the filled region plus the new slot
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CNT_W'(ram_wr_addr) <= count))
    else $error("slot write out of range");

  // a full status is only reported with a full queue
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_load && status == srtpq_pkg::STATUS_FULL) |-> count == CNT_W'(srtpq_pkg::DEPTH))
    else $error("full status with room left");

  // the loaded result carries the count as it stood at load
  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (rsp.entry_count == srtpq_pkg::COUNT_W'($past(count)) && rsp_valid))
    else $error("result count mismatch");

endmodule

/* hw/rtl/srtpq_ram.sv */
`timescale 1ns / 1ps

module srtpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* tb/sv/sorted_priority_queue_core_tb.sv */
`timescale 1ns / 1ps

// Sorted priority queue: every request returns exactly one result. The
// bench keeps its own copy of the slot list, predicts the head report for
// each accepted request, and matches results against the oldest pending one.

module sorted_priority_queue_core_tb;

  // Peek has no name in the package; mode 3 must behave as a peek too.
  localparam logic [1:0] MODE_PEEK     = 2'd2;
  localparam logic [1:0] MODE_PEEK_ALT = 2'd3;

  localparam logic [srtpq_pkg::TIME_W-1:0] TIME_DAY_MAX  = srtpq_pkg::TIME_W'(86399);
  localparam logic [srtpq_pkg::TIME_W-1:0] TIME_ALL_ONES = '1;

  // Room for the longest insert walk; leave plenty of slack at the end.
  localparam int DRAIN_CYCLES = 4 * srtpq_pkg::DEPTH + 16;

  logic clk;
  logic rst;

  srtpq_in_if  req_if ();
  srtpq_out_if rsp_if ();

  sorted_priority_queue_core uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (rsp_if)
  );

  // Shadow copy of the queue: slots 0..model_count-1 in serving order.
  srtpq_pkg::entry_t model_slots [srtpq_pkg::DEPTH];
  int unsigned       model_count = 0;

  // Head reports predicted for accepted requests, oldest first.
  srtpq_pkg::out_rsp_t pending_head_reports [$];

  int unsigned err_count = 0;

  // Random idle / stall enables, switched per phase.
  bit src_idle_en  = 1'b1;
  bit snk_stall_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop. Slowest correct run is roughly 1800 requests, each with a walk,
  // a sender gap and a receiver stall, about 130 us; this is many
  // times that.
  initial begin
    #2_000_000;
    $display("sorted_priority_queue_core_tb NOT OK");
    $finish;
  end

  // Apply one request to the shadow queue and return the head report.
  function automatic srtpq_pkg::out_rsp_t serve_queue_model(srtpq_pkg::in_req_t r);
    srtpq_pkg::out_rsp_t rep;
    srtpq_pkg::status_t  st;
    int unsigned         pos;
    bit                  found;
    st    = srtpq_pkg::STATUS_OK;
    found = 1'b0;
    if (r.mode == srtpq_pkg::MODE_INSERT) begin
      if (model_count >= srtpq_pkg::DEPTH) begin
        st = srtpq_pkg::STATUS_FULL;
      end else begin
        // Head is displaced only by a strictly smaller priority; otherwise
        // the new entry lands ahead of the first non-head entry that is
        // greater or equal, else at the tail.
        pos = model_count;
        if (model_count == 0 || model_slots[0].prio > r.new_priority) begin
          pos = 0;
        end else begin
          for (int unsigned i = 1; i < model_count; i++) begin
            if (!found && model_slots[i].prio >= r.new_priority) begin
              pos   = i;
              found = 1'b1;
            end
          end
        end
        for (int unsigned i = model_count; i > pos; i--) begin
          model_slots[i] = model_slots[i-1];
        end
        model_slots[pos].prio   = r.new_priority;
        model_slots[pos].plate  = r.plate_id;
        model_slots[pos].tstamp = r.entry_time;
        model_count++;
      end
    end else if (r.mode == srtpq_pkg::MODE_POP) begin
      if (model_count == 0) begin
        st = srtpq_pkg::STATUS_EMPTY;
      end else begin
        for (int unsigned i = 0; i + 1 < model_count; i++) begin
          model_slots[i] = model_slots[i+1];
        end
        model_count--;
      end
    end
    // Peek (mode 2 or 3) leaves the queue alone.
    rep        = '0;
    rep.status = st;
    if (model_count > 0) begin
      rep.head_valid    = 1'b1;
      rep.head_plate    = model_slots[0].plate;
      rep.head_priority = model_slots[0].prio;
      rep.head_time     = model_slots[0].tstamp;
    end
    rep.entry_count = model_count[srtpq_pkg::COUNT_W-1:0];
    return rep;
  endfunction

  // Sender: entered and left on a falling edge. valid is left high after
  // acceptance so back-to-back requests never drop and raise it in one step;
  // anything that stops sending lowers it itself.
  task automatic send_request(input srtpq_pkg::in_req_t r);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_head_reports.push_back(serve_queue_model(r));
    @(negedge clk);
  endtask

  task automatic send_cmd(input logic [1:0] mode,
                          input logic [srtpq_pkg::PLATE_W-1:0] plate,
                          input logic [srtpq_pkg::PRIO_W-1:0] prio,
                          input logic [srtpq_pkg::TIME_W-1:0] tm);
    srtpq_pkg::in_req_t r;
    r.mode         = mode;
    r.plate_id     = plate;
    r.new_priority = prio;
    r.entry_time   = tm;
    send_request(r);
  endtask

  // Stop sending until every predicted result has been seen.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    wait (pending_head_reports.size() == 0);
    @(negedge clk);
  endtask

  // wild: any mode and any field value the ports allow; otherwise the
  // insert share is steered to fill or drain the queue.
  function automatic srtpq_pkg::in_req_t random_request(int unsigned ins_pct, bit wild);
    srtpq_pkg::in_req_t r;
    int unsigned        pick;
    pick       = $urandom_range(0, 99);
    r.plate_id = $urandom();
    if (wild) begin
      r.mode         = 2'($urandom_range(0, 3));
      r.new_priority = srtpq_pkg::PRIO_W'($urandom_range(0, 15));
      r.entry_time   = srtpq_pkg::TIME_W'($urandom_range(0, TIME_ALL_ONES));
    end else begin
      if (pick < ins_pct) r.mode = srtpq_pkg::MODE_INSERT;
      else if (pick < 92) r.mode = srtpq_pkg::MODE_POP;
      else if (pick < 97) r.mode = MODE_PEEK;
      else r.mode = MODE_PEEK_ALT;
      r.new_priority = srtpq_pkg::PRIO_W'($urandom_range(1, 10));
      r.entry_time   = srtpq_pkg::TIME_W'($urandom_range(0, TIME_DAY_MAX));
    end
    return r;
  endfunction

  // Receiver: ready mostly high with random stall bursts.
  initial begin
    rsp_if.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (snk_stall_en && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Result checker, sampled on the rising edge.
  always @(posedge clk) begin
    srtpq_pkg::out_rsp_t want;
    srtpq_pkg::out_rsp_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_head_reports.size() == 0) begin
        $error("unexpected result: status %0d count %0d", got.status, got.entry_count);
        err_count++;
      end else begin
        want = pending_head_reports.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
        if (got.head_valid !== want.head_valid) begin
          $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
          err_count++;
        end
        if (got.head_plate !== want.head_plate) begin
          $error("head_plate: expected %0h, got %0h", want.head_plate, got.head_plate);
          err_count++;
        end
        if (got.head_priority !== want.head_priority) begin
          $error("head_priority: expected %0d, got %0d",
                 want.head_priority, got.head_priority);
          err_count++;
        end
        if (got.head_time !== want.head_time) begin
          $error("head_time: expected %0d, got %0d", want.head_time, got.head_time);
          err_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          err_count++;
        end
      end
    end
  end

  // Pop, peek and the spare mode on an empty queue: error only on pop,
  // head fields all zero.
  task automatic test_empty_queue();
    send_cmd(MODE_PEEK, 32'h1234_5678, 4'd3, 17'd100);
    send_cmd(srtpq_pkg::MODE_POP, 32'hFFFF_FFFF, 4'd15, TIME_ALL_ONES);
    send_cmd(MODE_PEEK_ALT, 32'h0, 4'd0, 17'd0);
  endtask

  // Sixteen inserts that hit head replacement, equal-to-head, tail and
  // middle placement plus out-of-range priorities, then insert when full.
  task automatic test_fill_to_full();
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0000, 4'd5, 17'd0);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 4'd5, TIME_DAY_MAX);  // equal to head
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hA5A5_A5A5, 4'd3, 17'd1);         // new head
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h5A5A_5A5A, 4'd3, TIME_ALL_ONES); // equal head again
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0001, 4'd10, 17'd2);        // tail
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0002, 4'd1, 17'd3);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0003, 4'd0, 17'd4);         // below range
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0004, 4'd15, 17'd5);        // above range
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0005, 4'd7, 17'd6);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h0000_0006, 4'd10, 17'd7);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h8000_0000, 4'd2, 17'd8);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 4'd4, 17'd9);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hDEAD_0001, 4'd6, 17'd10);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hDEAD_0002, 4'd8, 17'd11);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hDEAD_0003, 4'd9, 17'd12);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hDEAD_0004, 4'd1, 17'd13);
    send_cmd(srtpq_pkg::MODE_INSERT, 32'hBAD0_BAD0, 4'd1, 17'd14);        // queue full
    send_cmd(MODE_PEEK, 32'h0, 4'd0, 17'd0);
    send_cmd(MODE_PEEK_ALT, 32'hFFFF_FFFF, 4'd15, TIME_ALL_ONES);
  endtask

  task automatic test_pop_head();
    repeat (3) send_cmd(srtpq_pkg::MODE_POP, $urandom(), 4'd0, 17'd0);
  endtask

  // Alternating fill-heavy and drain-heavy phases so the queue swings
  // between full and empty with random content.
  task automatic test_fill_drain_cycles();
    for (int phase = 0; phase < 24; phase++) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      snk_stall_en = ($urandom_range(0, 3) != 0);
      repeat (50) send_request(random_request((phase % 2 == 0) ? 75 : 25, 1'b0));
      if (phase % 6 == 5) hold_until_drained();
    end
  endtask

  // Any mode, any priority nibble, any 17-bit time.
  task automatic test_wild_fields();
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    repeat (300) send_request(random_request(0, 1'b1));
  endtask

  // Closing stretch: no idling on either side.
  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    repeat (200) send_request(random_request(50, 1'b0));
  endtask

  initial begin
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_queue();
    test_fill_to_full();
    test_pop_head();
    test_fill_drain_cycles();
    test_wild_fields();
    test_back_to_back();

    req_if.valid <= 1'b0;
    wait (pending_head_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_head_reports.size() != 0) begin
      $error("%0d results never arrived", pending_head_reports.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("sorted_priority_queue_core_tb OK");
    end else begin
      $display("sorted_priority_queue_core_tb NOT OK");
    end
    $finish;
  end

endmodule
